// ===== rtl/cellular_automaton_row_smoother_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the row smoother checker
// ----------------------------------------------------------------------------
`ifndef CELLULAR_AUTOMATON_ROW_SMOOTHER_UNIT_ASSERT_SVH
`define CELLULAR_AUTOMATON_ROW_SMOOTHER_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define CARSM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define CARSM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, live through reset
`define CARSM_ASSERT_NXT_RAW(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/carsm_pkg.sv =====
// ----------------------------------------------------------------------------
// carsm_pkg
// Shared types and constants of the cellular automaton row smoother.
// ----------------------------------------------------------------------------
package carsm_pkg;

   localparam int MAX_ROW_WIDTH = 32;
   localparam int ROW_W         = 32;
   localparam int ROW_CAP       = (MAX_ROW_WIDTH < ROW_W) ? MAX_ROW_WIDTH : ROW_W;
   localparam int THR_W         = 4;
   localparam int WIDTH_W       = 6;
   localparam int CSR_DATA_W    = 6;

   localparam logic [THR_W-1:0]   BIRTH_RESET   = THR_W'(5);
   localparam logic [THR_W-1:0]   SURVIVE_RESET = THR_W'(3);
   localparam logic [WIDTH_W-1:0] WIDTH_RESET   = WIDTH_W'(24);

   localparam logic [ROW_W-1:0] ALL_ALIVE = '1;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   typedef enum logic [1:0] {
      REG_BIRTH   = 2'd0,
      REG_SURVIVE = 2'd1,
      REG_WIDTH   = 2'd2,
      REG_INVERT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0] birth;
      logic [THR_W-1:0] survive;
      logic [ROW_W-1:0] mask;
      logic             invert;
   } cfg_type;

   // up to two result rows per accepted input row
   typedef struct packed {
      logic [ROW_W-1:0] up_row;
      logic [ROW_W-1:0] mid_row;
      logic [ROW_W-1:0] down_row;
      logic             has_a;
      logic             a_last;
      logic             has_b;
   } job_type;

   typedef struct packed {
      logic [ROW_W-1:0] next_row;
      logic             last_out;
   } result_type;

endpackage

// ===== rtl/carsm_window.sv =====
// ----------------------------------------------------------------------------
// carsm_window
// Holds the two previous rows and registers the neighbourhood job per beat.
// ----------------------------------------------------------------------------
module carsm_window (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [carsm_pkg::ROW_W-1:0] row_cells,
   input  logic                     last_row,
   output carsm_pkg::job_type       job
);
   import carsm_pkg::*;

   logic [ROW_W-1:0] above_row_ff, above_row_in;
   logic [ROW_W-1:0] held_row_ff, held_row_in;
   logic             row_held_ff, row_held_in;
   job_type          job_ff, job_in;

   always_comb begin
      above_row_in = above_row_ff;
      held_row_in  = held_row_ff;
      row_held_in  = row_held_ff;
      job_in       = '0;
      job_in.up_row   = above_row_ff;
      job_in.mid_row  = held_row_ff;
      job_in.down_row = row_cells;
      if (accept) begin
         if (!row_held_ff) begin
            if (last_row) begin
               // single-row grid: live boundary above and below
               job_in.up_row   = ALL_ALIVE;
               job_in.mid_row  = row_cells;
               job_in.down_row = ALL_ALIVE;
               job_in.has_a    = 1'b1;
               job_in.a_last   = 1'b1;
            end else begin
               above_row_in = ALL_ALIVE;
               held_row_in  = row_cells;
               row_held_in  = 1'b1;
            end
         end else begin
            job_in.has_a = 1'b1;
            if (last_row) begin
               job_in.has_b = 1'b1;
               row_held_in  = 1'b0;
            end else begin
               above_row_in = held_row_ff;
               held_row_in  = row_cells;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      above_row_ff <= above_row_in;
      held_row_ff  <= held_row_in;
      job_ff.up_row   <= job_in.up_row;
      job_ff.mid_row  <= job_in.mid_row;
      job_ff.down_row <= job_in.down_row;
      if (reset) begin
         row_held_ff  <= 1'b0;
         job_ff.has_a <= 1'b0;
         job_ff.a_last <= 1'b0;
         job_ff.has_b <= 1'b0;
      end else begin
         row_held_ff  <= row_held_in;
         job_ff.has_a <= job_in.has_a;
         job_ff.a_last <= job_in.a_last;
         job_ff.has_b <= job_in.has_b;
      end
   end

   assign job = job_ff;

endmodule

// ===== rtl/carsm_row_gen.sv =====
// ----------------------------------------------------------------------------
// carsm_row_gen
// One generation of one row from its 3x3 neighbourhood rows.
// ----------------------------------------------------------------------------
module carsm_row_gen (
   input  logic [carsm_pkg::ROW_W-1:0] up_row,
   input  logic [carsm_pkg::ROW_W-1:0] mid_row,
   input  logic [carsm_pkg::ROW_W-1:0] down_row,
   input  carsm_pkg::cfg_type          cfg,
   output logic [carsm_pkg::ROW_W-1:0] next_row
);
   import carsm_pkg::*;

   function automatic logic [3:0] count8(input logic [7:0] bits);
      logic [3:0] sum;
      sum = '0;
      for (int i = 0; i < 8; i++) begin
         sum = sum + {3'b000, bits[i]};
      end
      return sum;
   endfunction

   // columns outside the grid, either side, count as alive
   logic [ROW_W+1:0] up_ext, mid_ext, dn_ext;
   logic [ROW_W-1:0] raw_row;

   assign up_ext  = {1'b1, up_row   | ~cfg.mask, 1'b1};
   assign mid_ext = {1'b1, mid_row  | ~cfg.mask, 1'b1};
   assign dn_ext  = {1'b1, down_row | ~cfg.mask, 1'b1};

   always_comb begin
      for (int k = 0; k < ROW_W; k++) begin
         logic [3:0] n;
         n = count8({up_ext[k+2 -: 3], dn_ext[k+2 -: 3], mid_ext[k], mid_ext[k+2]});
         raw_row[k] = (mid_ext[k+1] ? (n >= cfg.survive) : (n >= cfg.birth)) ^ cfg.invert;
      end
   end

   assign next_row = raw_row & cfg.mask;

endmodule

// ===== rtl/carsm_out_fifo.sv =====
// ----------------------------------------------------------------------------
// carsm_out_fifo
// Result queue: takes up to two rows per cycle, hands out one beat a cycle while pop is high.
// ----------------------------------------------------------------------------
module carsm_out_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_a,
   input  carsm_pkg::result_type        data_a,
   input  logic                         push_b,
   input  carsm_pkg::result_type        data_b,
   input  logic                         pop,
   output logic                         not_empty,
   output carsm_pkg::result_type        head,
   output logic [carsm_pkg::CNT_W-1:0]  fill
);
   import carsm_pkg::*;

   result_type       entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       n_push;
   logic             do_pop;

   assign n_push = {1'b0, push_a} + {1'b0, push_b};
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      count_in  = count_ff + CNT_W'(n_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         entry_ff[wr_ptr_ff] <= data_a;
      end
      if (push_b) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= data_b;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign fill      = count_ff;

endmodule

// ===== rtl/cellular_automaton_row_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// cellular_automaton_row_smoother_unit
// One generation of a binary cave automaton over a row-streamed grid.
// ----------------------------------------------------------------------------
//  channel  | ports                         | role
//  ---------+-------------------------------+-------------------------------
//  req      | req_valid/stall, row, last    | one grid row per beat
//  rsp      | rsp_valid/stall, row, last    | next generation, one row lag
//  csr      | csr_we, csr_index, csr_wdata  | thresholds, width, invert
//
//  One row accepted per cycle unless req_stall is high; a result for the row that
//  completes its neighbourhood passes the window register, then the result queue.
//  A last row after a held row pushes two results at once and can stall the input.
//  Reset clears the held-row flag and empties the four-entry result queue.
//  req_stall rises when the queue could not take a worst-case two-row beat.
// ----------------------------------------------------------------------------
module cellular_automaton_row_smoother_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [carsm_pkg::ROW_W-1:0]        req_row_cells,
   input  logic                               req_last_row,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [carsm_pkg::ROW_W-1:0]        rsp_next_row,
   output logic                               rsp_last_out,
   input  logic                               csr_we,
   input  carsm_pkg::csr_index_type           csr_index,
   input  logic [carsm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import carsm_pkg::*;

   logic [THR_W-1:0]   birth_ff;
   logic [THR_W-1:0]   survive_ff;
   logic [WIDTH_W-1:0] width_ff;
   logic               invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         birth_ff   <= BIRTH_RESET;
         survive_ff <= SURVIVE_RESET;
         width_ff   <= WIDTH_RESET;
         invert_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_BIRTH:   birth_ff   <= csr_wdata[THR_W-1:0];
            REG_SURVIVE: survive_ff <= csr_wdata[THR_W-1:0];
            REG_WIDTH:   width_ff   <= csr_wdata[WIDTH_W-1:0];
            REG_INVERT:  invert_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective width clamped to 1..cap, as a column mask
   cfg_type            cfg;
   logic [WIDTH_W-1:0] eff_width;

   always_comb begin
      if (width_ff == '0) begin
         eff_width = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(ROW_CAP)) begin
         eff_width = WIDTH_W'(ROW_CAP);
      end else begin
         eff_width = width_ff;
      end
      for (int k = 0; k < ROW_W; k++) begin
         cfg.mask[k] = (WIDTH_W'(k) < eff_width);
      end
      cfg.birth   = birth_ff;
      cfg.survive = survive_ff;
      cfg.invert  = invert_ff;
   end

   logic       req_beat;
   job_type    job;
   logic [ROW_W-1:0] row_a, row_b;
   result_type res_a, res_b, head;
   logic [CNT_W-1:0] fill;
   logic [CNT_W:0]   level;
   logic             not_empty;

   assign req_beat = req_valid && !req_stall;

   carsm_window u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_beat),
      .row_cells (req_row_cells),
      .last_row  (req_last_row),
      .job       (job)
   );

   carsm_row_gen u_gen_a (
      .up_row   (job.up_row),
      .mid_row  (job.mid_row),
      .down_row (job.down_row),
      .cfg      (cfg),
      .next_row (row_a)
   );

   // flushed final row: held and last rows, live boundary below
   carsm_row_gen u_gen_b (
      .up_row   (job.mid_row),
      .mid_row  (job.down_row),
      .down_row (ALL_ALIVE),
      .cfg      (cfg),
      .next_row (row_b)
   );

   assign res_a = '{next_row: row_a, last_out: job.a_last};
   assign res_b = '{next_row: row_b, last_out: 1'b1};

   carsm_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_a    (job.has_a),
      .data_a    (res_a),
      .push_b    (job.has_b),
      .data_b    (res_b),
      .pop       (!rsp_stall),
      .not_empty (not_empty),
      .head      (head),
      .fill      (fill)
   );

   // leave room for the job in flight plus a two-row beat
   assign level = {1'b0, fill} + (CNT_W+1)'(job.has_a) + (CNT_W+1)'(job.has_b);
   assign req_stall = (level > (CNT_W+1)'(FIFO_DEPTH - 2));

   assign rsp_valid    = not_empty;
   assign rsp_next_row = head.next_row;
   assign rsp_last_out = head.last_out;

endmodule

// ===== rtl/carsm_checker.sv =====
// ----------------------------------------------------------------------------
// carsm_checker
// Port-level checks on the row smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "cellular_automaton_row_smoother_unit_assert.svh"

module carsm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_last_row,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [carsm_pkg::ROW_W-1:0] rsp_next_row,
   input logic                        rsp_last_out
);
   import carsm_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   `CARSM_ASSERT_NXT_RAW(a_reset_empty, clock, reset, !rsp_valid, "result after reset")

   `CARSM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_next_row) && $stable(rsp_last_out), "stalled result beat changed")

   // a last row always leaves at least one result, through window register and queue
   `CARSM_ASSERT_NXT(a_last_drains, clock, reset, req_beat && req_last_row, ##1 rsp_valid, "last row gave no result")

   // nothing queued and nothing in flight: input must be open
   `CARSM_ASSERT_IMP(a_idle_open, clock, reset, !rsp_valid && !$past(req_beat), !req_stall, "stall with nothing in flight")

endmodule

bind cellular_automaton_row_smoother_unit carsm_checker u_carsm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_last_row (req_last_row),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_next_row (rsp_next_row),
   .rsp_last_out (rsp_last_out)
);

// ===== bench/tb_cellular_automaton_row_smoother_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cellular_automaton_row_smoother_unit
// Streams grids of rows through the smoother under several register settings
// and checks every result row against a row-level prediction of the next
// generation. Both channels idle at random; the csr port is only written
// while nothing is outstanding.
// ----------------------------------------------------------------------------
module tb_cellular_automaton_row_smoother_unit;
   import carsm_pkg::*;

   localparam int LIMIT_CYCLES  = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES        = 8;
   localparam int PHASE_ROWS    = 200;

   // -------------------------------------------------------------------------
   // scoreboard: next-generation predictor plus queue of rows still owed
   // -------------------------------------------------------------------------
   class row_smoother_scoreboard;
      logic [THR_W-1:0]   birth;
      logic [THR_W-1:0]   survive;
      logic [WIDTH_W-1:0] width;
      logic               invert;
      logic [ROW_W-1:0]   above;
      logic [ROW_W-1:0]   held;
      logic [1:0]         rows_seen;
      result_type         owed_rows[$];
      int                 mismatches;

      function new();
         birth      = BIRTH_RESET;
         survive    = SURVIVE_RESET;
         width      = WIDTH_RESET;
         invert     = 1'b0;
         above      = '0;
         held       = '0;
         rows_seen  = 2'd0;
         mismatches = 0;
      endfunction

      function void set_config(logic [THR_W-1:0] b, logic [THR_W-1:0] s,
                               logic [WIDTH_W-1:0] w, logic inv);
         birth   = b;
         survive = s;
         width   = w;
         invert  = inv;
      endfunction

      // width register clamped to 1..ROW_CAP
      function int span();
         int w;
         w = int'(width);
         if (w < 1) w = 1;
         if (w > ROW_CAP) w = ROW_CAP;
         return w;
      endfunction

      // columns outside the grid are alive
      function bit alive_at(logic [ROW_W-1:0] row, int k, int w);
         if (k < 0 || k >= w) return 1'b1;
         return row[k];
      endfunction

      function logic [ROW_W-1:0] next_generation(logic [ROW_W-1:0] up,
                                                 logic [ROW_W-1:0] mid,
                                                 logic [ROW_W-1:0] down,
                                                 int w);
         logic [ROW_W-1:0] gen;
         int               n;
         bit               nxt;
         gen = '0;
         for (int k = 0; k < w; k++) begin
            n = 0;
            for (int d = -1; d <= 1; d++) begin
               n += int'(alive_at(up, k + d, w));
               n += int'(alive_at(down, k + d, w));
               if (d != 0) n += int'(alive_at(mid, k + d, w));
            end
            if (!mid[k]) nxt = (n >= int'(birth));
            else nxt = (n >= int'(survive));
            gen[k] = nxt ^ invert;
         end
         return gen;
      endfunction

      function void owe(logic [ROW_W-1:0] row, logic last);
         result_type r;
         r.next_row = row;
         r.last_out = last;
         owed_rows.push_back(r);
      endfunction

      function void note_row(logic [ROW_W-1:0] row, logic last);
         int w;
         w = span();
         if (rows_seen == 2'd0) begin
            if (last) begin
               owe(next_generation(ALL_ALIVE, row, ALL_ALIVE, w), 1'b1);
            end else begin
               above     = ALL_ALIVE;
               held      = row;
               rows_seen = 2'd1;
            end
            return;
         end
         owe(next_generation(above, held, row, w), 1'b0);
         if (last) begin
            owe(next_generation(held, row, ALL_ALIVE, w), 1'b1);
            above     = '0;
            held      = '0;
            rows_seen = 2'd0;
         end else begin
            above     = held;
            held      = row;
            rows_seen = 2'd2;
         end
      endfunction

      task report(string what, logic [ROW_W-1:0] got, logic [ROW_W-1:0] want);
         if (mismatches < 50)
            $display("%0t: mismatch, %s: got %h, expected %h", $time, what, got, want);
         mismatches++;
      endtask

      task check_row(logic [ROW_W-1:0] row, logic last);
         result_type want;
         if (owed_rows.size() == 0) begin
            report("result with no row owed", row, '0);
            return;
         end
         want = owed_rows.pop_front();
         if (row !== want.next_row) report("next_row", row, want.next_row);
         if (last !== want.last_out) report("last_out", ROW_W'(last), ROW_W'(want.last_out));
      endtask

      task report_leftovers();
         while (owed_rows.size() != 0) begin
            report("result never arrived", '0, owed_rows[0].next_row);
            void'(owed_rows.pop_front());
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT and drive signals
   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [ROW_W-1:0]      req_row_cells;
   logic                  req_last_row;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ROW_W-1:0]      rsp_next_row;
   logic                  rsp_last_out;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   row_smoother_scoreboard sb = new();
   bit                     quiet;
   int                     rows_sent;

   cellular_automaton_row_smoother_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_row_cells (req_row_cells),
      .req_last_row  (req_last_row),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_next_row  (rsp_next_row),
      .rsp_last_out  (rsp_last_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("** cellular_automaton_row_smoother_unit: FAILED **");
      $finish;
   end

   // mostly short idles, the odd long one
   function int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // -------------------------------------------------------------------------
   // result side: random stall, check each accepted beat
   // -------------------------------------------------------------------------
   int  stall_left;
   bit  stalling;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_row(rsp_next_row, rsp_last_out);
      if (stall_left == 0) begin
         stalling   = ($urandom_range(0, 2) == 0);
         stall_left = stalling ? pick_gap() : $urandom_range(1, 8);
      end
      if (stall_left > 0) stall_left--;
      rsp_stall <= stalling && !quiet;
   end

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------
   task automatic send_row(logic [ROW_W-1:0] row, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_row_cells <= row;
      req_last_row  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_row(row, last);
      rows_sent++;
   endtask

   // wait until every owed row is back, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.owed_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_cfg(logic [THR_W-1:0] b, logic [THR_W-1:0] s,
                            logic [WIDTH_W-1:0] w, logic inv);
      csr_we    <= 1'b1;
      csr_index <= REG_BIRTH;
      csr_wdata <= CSR_DATA_W'(b);
      @(posedge clock);
      csr_index <= REG_SURVIVE;
      csr_wdata <= CSR_DATA_W'(s);
      @(posedge clock);
      csr_index <= REG_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= REG_INVERT;
      csr_wdata <= CSR_DATA_W'(inv);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_config(b, s, w, inv);
      repeat (2) @(posedge clock);
   endtask

   function logic [ROW_W-1:0] random_row();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return $urandom & $urandom & $urandom;
         3:       return $urandom | $urandom | $urandom;
         default: return $urandom;
      endcase
   endfunction

   function logic [THR_W-1:0] random_threshold();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return THR_W'($urandom_range(2, 6));
      if (r < 9) return THR_W'($urandom_range(0, 8));
      return THR_W'($urandom_range(9, 15));
   endfunction

   function logic [WIDTH_W-1:0] random_width();
      case ($urandom_range(0, 9))
         0:       return WIDTH_W'($urandom_range(1, 2));
         1:       return ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
         2:       return 6'(ROW_CAP);
         default: return WIDTH_W'($urandom_range(3, 32));
      endcase
   endfunction

   task automatic send_grid();
      int height;
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) height = 1;
      else if (r < 7) height = $urandom_range(2, 6);
      else height = $urandom_range(7, 40);
      for (int i = 0; i < height; i++) begin
         // now and then retune the width part way through a grid
         if (i > 0 && $urandom_range(0, 99) < 2) begin
            drain();
            write_cfg(sb.birth, sb.survive, random_width(), sb.invert);
         end
         send_row(random_row(), i == height - 1);
      end
   endtask

   initial begin
      int phase_start;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_row_cells <= '0;
      req_last_row  <= 1'b0;
      rsp_stall     <= 1'b0;
      csr_we        <= 1'b0;
      csr_index     <= REG_BIRTH;
      csr_wdata     <= '0;
      quiet         = 1'b1;
      stall_left    = 0;
      stalling      = 1'b0;
      rows_sent     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: reset settings, single-row grid then a short grid
      send_row('0, 1'b1);
      send_row('1, 1'b0);
      send_row('0, 1'b0);
      send_row(32'hA5A5_A5A5, 1'b1);
      // zero thresholds always hold, full width, inverted
      drain();
      write_cfg(4'd0, 4'd0, 6'd32, 1'b1);
      send_row(32'h1234_5678, 1'b0);
      send_row('0, 1'b1);
      // thresholds above eight never reached
      drain();
      write_cfg(4'd9, 4'd9, 6'd24, 1'b0);
      send_row('1, 1'b0);
      send_row(32'h0F0F_F0F0, 1'b0);
      send_row('0, 1'b1);
      // width of zero clamps to one column
      drain();
      write_cfg(4'd15, 4'd15, 6'd0, 1'b1);
      send_row('1, 1'b1);
      send_row('0, 1'b1);
      // widths beyond the row clamp to the full row
      drain();
      write_cfg(4'd5, 4'd3, 6'd63, 1'b0);
      send_row(32'h8000_0001, 1'b0);
      send_row(32'h7FFF_FFFE, 1'b0);
      send_row(32'hDEAD_BEEF, 1'b1);
      drain();
      write_cfg(4'd4, 4'd4, 6'd33, 1'b0);
      send_row(32'hFFFF_0000, 1'b0);
      send_row(32'h0000_FFFF, 1'b1);
      // width change inside a grid, with a later row held
      drain();
      write_cfg(4'd5, 4'd3, 6'd8, 1'b0);
      send_row(32'hFFFF_FF5A, 1'b0);
      send_row(32'h0000_00C3, 1'b0);
      drain();
      write_cfg(4'd5, 4'd3, 6'd20, 1'b0);
      send_row(32'h000F_0F0F, 1'b0);
      send_row(32'h0005_5555, 1'b1);
      // and with only the first row held
      drain();
      write_cfg(4'd5, 4'd3, 6'd12, 1'b1);
      send_row(32'hFFFF_F00F, 1'b0);
      drain();
      write_cfg(4'd5, 4'd3, 6'd30, 1'b1);
      send_row(32'h2AAA_AAAA, 1'b1);

      // random grids, a fresh register setting per phase, width retuned now and then
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         quiet = (ph == 0 || ph == 5);
         write_cfg(random_threshold(), random_threshold(), random_width(),
                   1'($urandom_range(0, 1)));
         phase_start = rows_sent;
         while (rows_sent - phase_start < PHASE_ROWS) send_grid();
      end

      drain();
      sb.report_leftovers();
      if (sb.mismatches == 0) begin
         $display("** cellular_automaton_row_smoother_unit: PASSED **");
      end else begin
         $display("** cellular_automaton_row_smoother_unit: FAILED **");
      end
      $finish;
   end

endmodule
